// ===== rtl/core/gaa_pkg.sv =====
// Types and constants shared by the grid authority arbiter modules
package gaa_pkg;

  typedef enum logic [2:0] {
    KIND_PROPOSAL  = 3'd0,
    KIND_ASSIGN    = 3'd1,
    KIND_REPORT    = 3'd2,
    KIND_ACTIVATE  = 3'd3,
    KIND_INACTIVE  = 3'd4,
    KIND_TRANSPORT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNAUTH  = 3'd1,
    ST_INVALID = 3'd2,
    ST_STALE   = 3'd3,
    ST_DUP     = 3'd4,
    ST_REJECT  = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  localparam logic [1:0] RUN_OK      = 2'd0;
  localparam logic [1:0] RUN_MISSING = 2'd1;
  localparam logic [1:0] MAX_MODE    = 2'd2;

  localparam logic [1:0] CFG_LOCAL       = 2'd0;
  localparam logic [1:0] CFG_COORDINATOR = 2'd1;
  localparam logic [1:0] CFG_ARRANGEMENT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_COMMIT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the request
    logic scan_clr;  // start of table search
    logic scan_step; // look at one slot
    logic commit;    // apply the update, form the result
  } gaa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_table; // request is a well-formed proposal or transport event
    logic scan_done;
  } gaa_sts_t;

endpackage

// ===== rtl/core/gaa_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read
module gaa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gaa_ctrl.sv =====
// Sequencer for the grid authority arbiter
module gaa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gaa_pkg::gaa_cmd_t cmd,
  input  gaa_pkg::gaa_sts_t sts
);
  import gaa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   state_next = sts.needs_table ? S_READ : S_COMMIT;
      S_READ:   if (sts.scan_done) state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:   cmd.scan_clr = 1'b1;
      S_READ:   cmd.scan_step = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("result not shown after commit");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cmd.load) else $error("request taken while result pending");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit) else $error("double commit");
`endif

endmodule

// ===== rtl/core/gaa_dpath.sv =====
// Grid record, peer tables and decision logic
module gaa_dpath #(
  parameter int PEER_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gaa_pkg::gaa_cmd_t cmd,
  output gaa_pkg::gaa_sts_t sts,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic [2:0]        kind,
  input  logic [63:0]       source_peer,
  input  logic [63:0]       request_counter,
  input  logic [63:0]       revision_in,
  input  logic [63:0]       authority_peer_in,
  input  logic [1:0]        mode_in,
  input  logic [1:0]        run_state_in,
  input  logic              lead_audio_claim,
  input  logic              epoch_restart,
  input  logic [63:0]       auth_epoch_in,
  input  logic [63:0]       auth_packet_in,
  input  logic              needs_arrangement_authority,
  output logic [2:0]        status,
  output logic [63:0]       grid_rev,
  output logic [63:0]       grid_authority_peer,
  output logic [1:0]        grid_run_state,
  output logic [1:0]        grid_mode,
  output logic [63:0]       grid_epoch_frame,
  output logic [63:0]       grid_packet_frame,
  output logic              grid_epoch_reset,
  output logic              local_is_authority
);
  import gaa_pkg::*;

  localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(PEER_SLOTS);

  logic [63:0] local_peer, coordinator_peer, arrangement_peer;

  // captured request
  logic [2:0]  r_kind;
  logic [63:0] r_src, r_ctr, r_rev, r_apeer, r_ef, r_pf;
  logic [1:0]  r_mode, r_run;
  logic        r_claim, r_rst, r_narr;

  // grid record
  logic [63:0] cur_revision, cur_authority_peer, cur_epoch_frame, cur_packet_frame;
  logic [1:0]  cur_run_state, cur_mode;
  logic        cur_epoch_reset;
  logic [63:0] cur_revision_next, cur_authority_peer_next;
  logic [63:0] cur_epoch_frame_next, cur_packet_frame_next;
  logic [1:0]  cur_run_state_next, cur_mode_next;
  logic        cur_epoch_reset_next;

  // tables: peer and last ids in RAM, used bits in flops
  logic [PEER_SLOTS-1:0] p_used, t_used;
  logic [PEER_SLOTS-1:0] p_used_next, t_used_next;
  logic [CW-1:0] scan_cnt;     // slot whose data arrives this cycle is scan_cnt-1
  logic [IW-1:0] raddr, hit_slot, free_slot, waddr;
  logic          hit, free_ok;
  logic [63:0]   peer_rd, last_rd, hit_last;
  logic          we;
  logic [63:0]   w_last;
  logic [63:0]   p_peer_rd, p_last_rd, t_peer_rd, t_last_rd;
  logic          use_trans;
  logic [PEER_SLOTS-1:0] used_sel;
  logic          rd_pending;
  logic [IW-1:0] rd_slot;

  assign use_trans = (r_kind == KIND_TRANSPORT);
  assign used_sel  = use_trans ? t_used : p_used;
  assign raddr     = scan_cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      local_peer       <= 64'd1;
      coordinator_peer <= 64'd1;
      arrangement_peer <= 64'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOCAL:       local_peer <= cfg_data;
        CFG_COORDINATOR: coordinator_peer <= cfg_data;
        CFG_ARRANGEMENT: arrangement_peer <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_kind  <= kind;
      r_src   <= source_peer;
      r_ctr   <= request_counter;
      r_rev   <= revision_in;
      r_apeer <= authority_peer_in;
      r_mode  <= mode_in;
      r_run   <= run_state_in;
      r_claim <= lead_audio_claim;
      r_rst   <= epoch_restart;
      r_ef    <= auth_epoch_in;
      r_pf    <= auth_packet_in;
      r_narr  <= needs_arrangement_authority;
    end
  end

  // precheck for table kinds
  logic prop_ok, trans_ok;
  assign prop_ok = (local_peer == coordinator_peer) && (r_src != '0) && (r_ctr != '0)
                   && (r_mode <= MAX_MODE) && !(r_claim && r_mode != 2'd1)
                   && (r_run == RUN_OK) && (cur_revision != '1);
  assign trans_ok = (r_src != '0) && (r_ctr != '0) && (r_rev == cur_revision)
                    && !(r_narr && r_src != arrangement_peer);
  assign sts.needs_table = (r_kind == KIND_PROPOSAL && prop_ok) ||
                           (r_kind == KIND_TRANSPORT && trans_ok);
  assign sts.scan_done = (scan_cnt == LAST_CNT) && !rd_pending;

  gaa_ram #(.WIDTH(64), .DEPTH(PEER_SLOTS)) u_p_peer (
    .clk, .we(we && !use_trans), .waddr, .wdata(r_src), .raddr, .rdata(p_peer_rd));
  gaa_ram #(.WIDTH(64), .DEPTH(PEER_SLOTS)) u_p_last (
    .clk, .we(we && !use_trans), .waddr, .wdata(w_last), .raddr, .rdata(p_last_rd));
  gaa_ram #(.WIDTH(64), .DEPTH(PEER_SLOTS)) u_t_peer (
    .clk, .we(we && use_trans), .waddr, .wdata(r_src), .raddr, .rdata(t_peer_rd));
  gaa_ram #(.WIDTH(64), .DEPTH(PEER_SLOTS)) u_t_last (
    .clk, .we(we && use_trans), .waddr, .wdata(w_last), .raddr, .rdata(t_last_rd));

  assign peer_rd = use_trans ? t_peer_rd : p_peer_rd;
  assign last_rd = use_trans ? t_last_rd : p_last_rd;

  // one slot issued per cycle, its data compared the cycle after
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_cnt   <= '0;
      hit        <= 1'b0;
      free_ok    <= 1'b0;
      rd_pending <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_cnt != LAST_CNT) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      rd_pending <= (scan_cnt != LAST_CNT);
      rd_slot    <= raddr;
      if (rd_pending) begin
        if (used_sel[rd_slot]) begin
          if (!hit && peer_rd == r_src) begin
            hit      <= 1'b1;
            hit_slot <= rd_slot;
            hit_last <= last_rd;
          end
        end else if (!free_ok) begin
          free_ok   <= 1'b1;
          free_slot <= rd_slot;
        end
      end
    end
  end

  status_t st;
  logic    tab_upd;

  always_comb begin
    st      = ST_INVALID;
    tab_upd = 1'b0;
    if (hit) begin
      if (r_ctr <= hit_last) begin
        st = ST_DUP;
      end else begin
        st = ST_OK;
        tab_upd = 1'b1;
      end
    end else if (free_ok) begin
      st = ST_OK;
      tab_upd = 1'b1;
    end else begin
      st = ST_FULL;
    end
  end

  assign waddr  = hit ? hit_slot : free_slot;
  assign w_last = r_ctr;
  assign we     = cmd.commit && sts.needs_table && tab_upd;

  logic lauth;
  assign lauth = (cur_revision != '0) && (cur_authority_peer == local_peer)
                 && (cur_run_state != RUN_MISSING);

  status_t res;

  always_comb begin
    cur_revision_next       = cur_revision;
    cur_authority_peer_next = cur_authority_peer;
    cur_run_state_next      = cur_run_state;
    cur_mode_next           = cur_mode;
    cur_epoch_frame_next    = cur_epoch_frame;
    cur_packet_frame_next   = cur_packet_frame;
    cur_epoch_reset_next    = cur_epoch_reset;
    p_used_next             = p_used;
    t_used_next             = t_used;
    res                     = ST_INVALID;
    case (r_kind)
      KIND_PROPOSAL: begin
        if (!prop_ok) begin
          res = ST_REJECT;
        end else begin
          res = st;
          if (st == ST_OK) begin
            if (!hit) p_used_next[free_slot] = 1'b1;
            if (cur_revision == '0) cur_authority_peer_next = coordinator_peer;
            else if (r_claim) cur_authority_peer_next = r_src;
            else if (cur_run_state != RUN_MISSING) begin
              if (cur_authority_peer == '0) cur_authority_peer_next = coordinator_peer;
            end else cur_authority_peer_next = coordinator_peer;
            cur_revision_next  = cur_revision + 64'd1;
            cur_run_state_next = RUN_OK;
            cur_mode_next      = r_mode;
            if (r_rst) begin
              cur_epoch_frame_next  = '0;
              cur_packet_frame_next = '0;
            end
            cur_epoch_reset_next = r_rst;
          end
        end
      end
      KIND_ASSIGN: begin
        if (r_src != coordinator_peer) res = ST_UNAUTH;
        else if (r_rev == '0 || r_apeer == '0 || r_mode > MAX_MODE || r_run != RUN_OK)
          res = ST_INVALID;
        else if (r_rev < cur_revision) res = ST_STALE;
        else if (r_rev == cur_revision)
          res = (r_apeer == cur_authority_peer && r_run == cur_run_state
                 && r_mode == cur_mode) ? ST_DUP : ST_STALE;
        else begin
          cur_revision_next       = r_rev;
          cur_authority_peer_next = r_apeer;
          cur_run_state_next      = r_run;
          cur_mode_next           = r_mode;
          cur_epoch_frame_next    = r_ef;
          cur_packet_frame_next   = r_pf;
          cur_epoch_reset_next    = r_rst;
          res = ST_OK;
        end
      end
      KIND_REPORT: begin
        if (cur_revision == '0 || r_rev != cur_revision)
          res = (r_rev < cur_revision) ? ST_STALE : ST_INVALID;
        else if (r_src != cur_authority_peer || r_apeer != cur_authority_peer)
          res = ST_UNAUTH;
        else if (r_mode > MAX_MODE || r_run != RUN_OK) res = ST_INVALID;
        else begin
          cur_run_state_next    = r_run;
          cur_mode_next         = r_mode;
          cur_epoch_frame_next  = r_ef;
          cur_packet_frame_next = r_pf;
          res = ST_OK;
        end
      end
      KIND_ACTIVATE: begin
        if (!lauth) res = ST_UNAUTH;
        else begin
          cur_epoch_frame_next  = r_ef;
          cur_packet_frame_next = r_pf;
          res = ST_OK;
        end
      end
      KIND_INACTIVE: begin
        if (cur_revision == '0 || r_src == '0 || r_src != cur_authority_peer
            || cur_run_state == RUN_MISSING) res = ST_REJECT;
        else begin
          cur_run_state_next = RUN_MISSING;
          res = ST_OK;
        end
      end
      KIND_TRANSPORT: begin
        if (!trans_ok) res = ST_REJECT;
        else begin
          res = st;
          if (st == ST_OK && !hit) t_used_next[free_slot] = 1'b1;
        end
      end
      default: res = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_revision       <= '0;
      cur_authority_peer <= '0;
      cur_run_state      <= RUN_OK;
      cur_mode           <= '0;
      cur_epoch_frame    <= '0;
      cur_packet_frame   <= '0;
      cur_epoch_reset    <= 1'b0;
      p_used             <= '0;
      t_used             <= '0;
    end else if (cmd.commit) begin
      cur_revision       <= cur_revision_next;
      cur_authority_peer <= cur_authority_peer_next;
      cur_run_state      <= cur_run_state_next;
      cur_mode           <= cur_mode_next;
      cur_epoch_frame    <= cur_epoch_frame_next;
      cur_packet_frame   <= cur_packet_frame_next;
      cur_epoch_reset    <= cur_epoch_reset_next;
      p_used             <= p_used_next;
      t_used             <= t_used_next;
      status             <= res;
    end
  end

  assign grid_rev            = cur_revision;
  assign grid_authority_peer = cur_authority_peer;
  assign grid_run_state      = cur_run_state;
  assign grid_mode           = cur_mode;
  assign grid_epoch_frame    = cur_epoch_frame;
  assign grid_packet_frame   = cur_packet_frame;
  assign grid_epoch_reset    = cur_epoch_reset;
  assign local_is_authority  = lauth;

`ifndef SYNTHESIS
  a_rev_mono: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> cur_revision >= $past(cur_revision))
    else $error("grid revision went backwards");
  a_used_grow: assert property (@(posedge clk) disable iff (rst)
    ((p_used & ~$past(p_used)) == '0) || $past(cmd.commit))
    else $error("proposal table changed outside commit");
  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    $countones(p_used ^ $past(p_used)) <= 1)
    else $error("more than one proposal slot claimed");
`endif

endmodule

// ===== rtl/core/grid_authority_arbiter_unit.sv =====
// Grid authority arbiter top level
// Sequence: a taken request is checked first; proposals and transport events that
// pass their checks then search the table RAM one slot a cycle and wait for the
// last registered read; the result is formed at commit and held until taken.
// Throughput: one request at a time; a new request is taken only after the
// result is taken. Reset: synchronous; grid record zero, tables empty, peer id
// registers 1.
module grid_authority_arbiter_unit #(
  parameter int PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [63:0] source_peer,
  input  logic [63:0] request_counter,
  input  logic [63:0] revision_in,
  input  logic [63:0] authority_peer_in,
  input  logic [1:0]  mode_in,
  input  logic [1:0]  run_state_in,
  input  logic        lead_audio_claim,
  input  logic        epoch_restart,
  input  logic [63:0] auth_epoch_in,
  input  logic [63:0] auth_packet_in,
  input  logic        needs_arrangement_authority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] grid_rev,
  output logic [63:0] grid_authority_peer,
  output logic [1:0]  grid_run_state,
  output logic [1:0]  grid_mode,
  output logic [63:0] grid_epoch_frame,
  output logic [63:0] grid_packet_frame,
  output logic        grid_epoch_reset,
  output logic        local_is_authority
);
  import gaa_pkg::*;

  gaa_cmd_t cmd;
  gaa_sts_t sts;

  assign cfg_ready = 1'b1;

  gaa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts);

  gaa_dpath #(.PEER_SLOTS(PEER_SLOTS)) u_dpath (
    .clk, .rst, .cmd, .sts,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .kind, .source_peer, .request_counter, .revision_in, .authority_peer_in,
    .mode_in, .run_state_in, .lead_audio_claim, .epoch_restart,
    .auth_epoch_in, .auth_packet_in, .needs_arrangement_authority,
    .status, .grid_rev, .grid_authority_peer, .grid_run_state, .grid_mode,
    .grid_epoch_frame, .grid_packet_frame, .grid_epoch_reset, .local_is_authority);

endmodule
